### design/mke_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and elaboration-time functions for the Matern 5/2 kernel block.
package mke_pkg;

	localparam int NUM_STAGES = 17;
	localparam int FRAC_STEPS = 10;

	localparam int SIL_W = 24;
	localparam int SV_W  = 32;
	localparam int PT_W  = 32;
	localparam int KV_W  = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	localparam logic [SIL_W-1:0] SIL_RESET = 24'd146543;
	localparam logic [SV_W-1:0]  SV_RESET  = 32'd65536;

	localparam logic [31:0] LOG2E_Q31 = 32'hB8AA_3B29;
	localparam logic [31:0] LN2_Q32   = 32'hB172_17F8;

	// reciprocals of 3 for 18-bit and 22-bit dividends
	localparam logic [17:0] DIV3_HI = 18'd174763;
	localparam logic [21:0] DIV3_LO = 22'd2796203;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SIL = 1'b0,
		CFG_SV  = 1'b1
	} cfg_idx_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] bit_v;
		rem   = v;
		res   = '0;
		bit_v = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (rem >= res + bit_v) begin
				rem = rem - (res + bit_v);
				res = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return res;
	endfunction

	// 2^(-2^-k) in Q1.31
	function automatic logic [31:0] frac_const(input int k);
		logic [63:0] c;
		c = isqrt64(64'd1 << 61);
		for (int j = 1; j < k; j++) begin
			c = isqrt64(c << 31);
		end
		return c[31:0];
	endfunction

endpackage

### design/matern_kernel_evaluator_top.sv
`timescale 1ns / 1ps
// Matern 5/2 covariance evaluator: seventeen-stage pipeline, one point pair per cycle unless stalled.
//
// Usage:
//   Input channel: pair_valid / pair_stall carry one word of two signed Q16.16
//   positions (point_a, point_b). Output channel: kernel_valid / kernel_stall carry
//   one word, kernel_value, unsigned Q16.16, for every accepted pair, in order.
//   Configuration: cfg_we writes cfg_data into register cfg_idx (0: scaled inverse
//   length, Q8.16; 1: signal variance, Q16.16). Write only while no pair is in flight.
//   Path: an accepted pair is registered in stage 1 and advances through stages 2 to
//   17 in order; kernel_valid is the valid bit of stage 17.
//   Throughput: one pair per cycle unless stalled; no stage has more than one
//   multiplier in series, and the exp fraction factors take stages 4 to 13.
//   Stall: a stalled output word holds; stages behind it keep filling empty slots,
//   and pair_stall rises only when all 17 stages hold a word and kernel_stall is high.
//   Reset: arst_n clears all valid bits and loads the register defaults
//   (scaled inverse length sqrt(5), signal variance 1.0).
module matern_kernel_evaluator_top
	import mke_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  pair_valid,
	output logic                  pair_stall,
	input  logic signed [PT_W-1:0] point_a,
	input  logic signed [PT_W-1:0] point_b,
	output logic                  kernel_valid,
	input  logic                  kernel_stall,
	output logic [KV_W-1:0]       kernel_value
);

	localparam logic [31:0] FRAC_C1 = frac_const(1);

	logic [SIL_W-1:0] sil_q;
	logic [SV_W-1:0]  sv_q;

	logic [NUM_STAGES:1] vld_q;
	logic [NUM_STAGES:1] en;

	logic [31:0] r_s1;
	logic [31:0] s_s [2:6];
	logic        under_s [2:16];
	logic [37:0] sq_s3;
	logic [5:0]  n_s [3:16];
	logic [FRAC_STEPS-1:0] fb_s [3:12];
	logic [21:0] g_s3;
	logic [37:0] x_s4;
	logic [22:0] ypr_s4;
	logic [31:0] m_s [4:14];
	logic [16:0] qh_s5;
	logic [17:0] xh_s5;
	logic [19:0] xl_s5;
	logic [22:0] y_s [5:6];
	logic [12:0] yyh_s6;
	logic [16:0] qh_s6;
	logic [19:0] ql_s6;
	logic [36:0] q_s7;
	logic [32:0] p_s7;
	logic [31:0] q22_s [8:14];
	logic [31:0] p31_s [8:13];
	logic [31:0] qm_s15;
	logic [63:0] vp_s16;
	logic [31:0] kv_s17;

	logic signed [32:0] diff;
	logic [32:0] mag;
	logic [55:0] prod2;
	logic [63:0] ss3;
	logic [63:0] tt3;
	logic [53:0] yp4;
	logic [35:0] qhp5;
	logic [17:0] rhf6;
	logic [21:0] low6;
	logic [43:0] qlp6;
	logic [45:0] yy6;
	logic [63:0] mp14;
	logic [63:0] qmp15;
	logic [41:0] qmf15;
	logic [5:0]  sh17;
	logic [63:0] vsh17;
	logic [34:0] vr17;
	logic        zero17;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sil_q <= SIL_RESET;
			sv_q  <= SV_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_idx))
				CFG_SIL: sil_q <= cfg_data[SIL_W-1:0];
				CFG_SV:  sv_q  <= cfg_data[SV_W-1:0];
				default: ;
			endcase
		end
	end

	for (genvar g = 1; g <= NUM_STAGES; g++) begin : g_en
		assign en[g] = !kernel_stall || !(&vld_q[NUM_STAGES:g]);
	end

	assign pair_stall = !en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (vld_q & ~en) | ({vld_q[NUM_STAGES-1:1], pair_valid} & en);
		end
	end

	// stage 1: distance
	always_comb begin
		diff = 33'(point_a) - 33'(point_b);
		mag  = diff[32] ? (~diff + 33'd1) : diff;
	end

	always_ff @(posedge clk) begin
		if (en[1]) r_s1 <= mag[31:0];
	end

	// stage 2: s = c1 * r
	assign prod2 = 56'(sil_q) * 56'(r_s1);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			under_s[2] <= |prod2[55:37];
			s_s[2]     <= prod2[36:5];
		end
	end

	// stage 3: s squared and s * log2(e)
	assign ss3 = 64'(s_s[2]) * 64'(s_s[2]);
	assign tt3 = 64'(s_s[2]) * 64'(LOG2E_Q31);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			sq_s3    <= ss3[63:26];
			n_s[3]   <= tt3[63:58];
			fb_s[3]  <= tt3[57:58-FRAC_STEPS];
			g_s3     <= tt3[47:26];
		end
	end

	// stage 4: rounded square plus one LSB, ln2 scaling of the low fraction, first factor
	assign yp4 = 54'(g_s3) * 54'(LN2_Q32);

	always_ff @(posedge clk) begin
		if (en[4]) begin
			x_s4   <= 38'(sq_s3[37:1]) + 38'(sq_s3[0]) + 38'd1;
			ypr_s4 <= yp4[53:31];
			m_s[4] <= fb_s[3][FRAC_STEPS-1] ? FRAC_C1 : 32'h8000_0000;
		end
	end

	// stage 5: high digit of the divide by three, round y
	assign qhp5 = 36'(x_s4[37:20]) * 36'(DIV3_HI);

	always_ff @(posedge clk) begin
		if (en[5]) begin
			qh_s5  <= qhp5[35:19];
			xh_s5  <= x_s4[37:20];
			xl_s5  <= x_s4[19:0];
			y_s[5] <= 23'(ypr_s4[22:1]) + 23'(ypr_s4[0]);
		end
	end

	// stage 6: low digit of the divide by three, y squared
	always_comb begin
		rhf6 = xh_s5 - {qh_s5, 1'b0} - 18'(qh_s5);
		low6 = {rhf6[1:0], xl_s5};
		qlp6 = 44'(low6) * 44'(DIV3_LO);
		yy6  = 46'(y_s[5]) * 46'(y_s[5]);
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			qh_s6  <= qh_s5;
			ql_s6  <= qlp6[42:23];
			yyh_s6 <= yy6[45:33];
			y_s[6] <= y_s[5];
		end
	end

	// stage 7: polynomial term and exp quadratic
	always_ff @(posedge clk) begin
		if (en[7]) begin
			q_s7 <= (37'd1 << 27) + 37'(s_s[6]) + {qh_s6, ql_s6};
			p_s7 <= (33'd1 << 32) - 33'(y_s[6]) + 33'(yyh_s6);
		end
	end

	// stage 8: round both to their product formats
	always_ff @(posedge clk) begin
		if (en[8]) begin
			q22_s[8] <= 32'(q_s7[36:5]) + 32'(q_s7[4]);
			p31_s[8] <= 32'(p_s7[32:1]) + 32'(p_s7[0]);
		end
	end

	// stages 5 to 13: remaining fraction factors
	for (genvar k = 2; k <= FRAC_STEPS; k++) begin : g_frac
		localparam int ST = k + 3;
		localparam logic [31:0] CK = frac_const(k);
		logic [63:0] mc;
		assign mc = 64'(m_s[ST-1]) * 64'(CK) + (64'd1 << 30);
		always_ff @(posedge clk) begin
			if (en[ST]) m_s[ST] <= fb_s[ST-1][FRAC_STEPS-k] ? mc[62:31] : m_s[ST-1];
		end
	end

	// stage 14: apply the quadratic remainder
	assign mp14 = 64'(m_s[13]) * 64'(p31_s[13]) + (64'd1 << 30);

	always_ff @(posedge clk) begin
		if (en[14]) m_s[14] <= mp14[62:31];
	end

	// stage 15: polynomial times exp, saturate
	always_comb begin
		qmp15 = 64'(q22_s[14]) * 64'(m_s[14]) + (64'd1 << 21);
		qmf15 = qmp15[63:22];
	end

	always_ff @(posedge clk) begin
		if (en[15]) qm_s15 <= (|qmf15[41:32]) ? '1 : qmf15[31:0];
	end

	// stage 16: variance scaling
	always_ff @(posedge clk) begin
		if (en[16]) vp_s16 <= 64'(sv_q) * 64'(qm_s15);
	end

	// stage 17: integer power of two, round, saturate, underflow
	always_comb begin
		sh17   = 6'd30 + n_s[16];
		vsh17  = vp_s16 >> sh17;
		vr17   = 35'(vsh17[33:0]) + 35'd1;
		zero17 = under_s[16] || (n_s[16] > 6'd32);
	end

	always_ff @(posedge clk) begin
		if (en[17]) begin
			if (zero17) begin
				kv_s17 <= '0;
			end else if (|vr17[34:33]) begin
				kv_s17 <= '1;
			end else begin
				kv_s17 <= vr17[32:1];
			end
		end
	end

	// carried fields
	for (genvar st = 3; st <= 6; st++) begin : g_s
		always_ff @(posedge clk) begin
			if (en[st]) s_s[st] <= s_s[st-1];
		end
	end

	for (genvar st = 3; st <= 16; st++) begin : g_under
		always_ff @(posedge clk) begin
			if (en[st]) under_s[st] <= under_s[st-1];
		end
	end

	for (genvar st = 4; st <= 16; st++) begin : g_n
		always_ff @(posedge clk) begin
			if (en[st]) n_s[st] <= n_s[st-1];
		end
	end

	for (genvar st = 4; st <= 12; st++) begin : g_fb
		always_ff @(posedge clk) begin
			if (en[st]) fb_s[st] <= fb_s[st-1];
		end
	end

	for (genvar st = 9; st <= 14; st++) begin : g_q22
		always_ff @(posedge clk) begin
			if (en[st]) q22_s[st] <= q22_s[st-1];
		end
	end

	for (genvar st = 9; st <= 13; st++) begin : g_p31
		always_ff @(posedge clk) begin
			if (en[st]) p31_s[st] <= p31_s[st-1];
		end
	end

	assign kernel_valid = vld_q[NUM_STAGES];
	assign kernel_value = kv_s17;

endmodule

### design/mke_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the Matern 5/2 kernel block, bound to the top level.
module mke_checker
	import mke_pkg::*;
(
	input logic            clk,
	input logic            arst_n,
	input logic            pair_valid,
	input logic            pair_stall,
	input logic            kernel_valid,
	input logic            kernel_stall,
	input logic [KV_W-1:0] kernel_value
);

	localparam int CW = $clog2(NUM_STAGES + 1);

	logic [CW-1:0] in_flight_q;
	logic          acc_in;
	logic          acc_out;

	assign acc_in  = pair_valid && !pair_stall;
	assign acc_out = kernel_valid && !kernel_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_flight_q <= '0;
		end else begin
			in_flight_q <= in_flight_q + CW'(acc_in) - CW'(acc_out);
		end
	end

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		in_flight_q <= CW'(NUM_STAGES))
		else $error("more words in flight than pipeline stages");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		kernel_valid |-> in_flight_q != '0)
		else $error("result word with no pair in flight");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		pair_stall |-> kernel_stall && in_flight_q == CW'(NUM_STAGES))
		else $error("input stalled while the pipeline has room");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		kernel_valid && kernel_stall |=> kernel_valid && $stable(kernel_value))
		else $error("stalled result word changed");

endmodule

bind matern_kernel_evaluator_top mke_checker u_mke_checker (.*);
